// File: rtl/pupw_pkg.sv
// ----------------------------------------------------------------------------
// pupw_pkg
// Shared widths, codes and stream layout for the palette upscale pixel writer.
// ----------------------------------------------------------------------------
package pupw_pkg;

    localparam int CODE_W     = 8;
    localparam int CODE_SPAN  = 2 ** CODE_W;
    localparam int COLOR_W    = 8;
    localparam int RGB_W      = 3 * COLOR_W;
    localparam int ADDR_W     = 22;
    localparam int CFG_W      = 9;
    localparam int ZOOM_W     = 4;
    localparam int CFG_IDX_W  = 2;

    // slave tdata: code, red, green, blue
    localparam int IN_TDATA_W  = CODE_W + RGB_W;
    // master tdata: pixel_address, red, green, blue, zero pad to whole bytes
    localparam int OUT_FIELD_W = ADDR_W + RGB_W;
    localparam int OUT_TDATA_W = ((OUT_FIELD_W + 7) / 8) * 8;

    typedef enum logic
    {
        FUNC_LOAD  = 1'b0,
        FUNC_PIXEL = 1'b1
    } func_t;

    typedef enum logic [CFG_IDX_W-1:0]
    {
        CFG_IMAGE_WIDTH  = 2'd0,
        CFG_IMAGE_HEIGHT = 2'd1,
        CFG_ZOOM_FACTOR  = 2'd2
    } cfg_index_t;

endpackage

// File: rtl/palette_upscale_pixel_writer.sv
// ----------------------------------------------------------------------------
// palette_upscale_pixel_writer
// Palette lookup of thermal codes, nearest-neighbor integer upscale writes.
// First write of a pixel leaves the output register after its slave transfer
//   passes palette read (S1), zoom products (S2) and address generation (G).
// Each pixel gives zoom*zoom writes, one write per cycle from the output
//   register while m_axis_tready is high; a palette load yields no write.
// Reset: column/row counters zero, image_width 256, image_height 248, zoom 1;
//   the palette RAM is not cleared and holds garbage until loaded.
// ----------------------------------------------------------------------------
module palette_upscale_pixel_writer
    import pupw_pkg::*;
#(
    parameter int MAX_WIDTH     = 256,
    parameter int MAX_HEIGHT    = 256,
    parameter int MAX_ZOOM      = 8,
    parameter int PALETTE_DEPTH = 256
)
(
    input  logic                   clk,
    input  logic                   rst_n,

    // source items
    input  logic                   s_axis_tvalid,
    output logic                   s_axis_tready,
    input  logic [IN_TDATA_W-1:0]  s_axis_tdata,   // code, red_in, green_in, blue_in
    input  logic                   s_axis_tuser,   // func

    // pixel writes
    output logic                   m_axis_tvalid,
    input  logic                   m_axis_tready,
    output logic [OUT_TDATA_W-1:0] m_axis_tdata,   // pixel_address, red, green, blue, pad
    output logic                   m_axis_tlast,   // run_last
    output logic                   m_axis_tuser,   // frame_last

    // register writes
    input  logic                   cfg_valid,
    output logic                   cfg_ready,
    input  logic [CFG_IDX_W-1:0]   cfg_index,
    input  logic [CFG_W-1:0]       cfg_data
);

    // counter widths: column/row hold 0..MAX-1, clamped sizes hold 1..MAX
    localparam int CW  = (MAX_WIDTH  > 1) ? $clog2(MAX_WIDTH)  : 1;
    localparam int RW  = (MAX_HEIGHT > 1) ? $clog2(MAX_HEIGHT) : 1;
    localparam int WW  = $clog2(MAX_WIDTH + 1);
    localparam int HW  = $clog2(MAX_HEIGHT + 1);
    localparam int ZCW = $clog2(MAX_ZOOM + 1);
    localparam int DW  = (MAX_ZOOM > 1) ? $clog2(MAX_ZOOM) : 1;
    localparam int PW  = $clog2(PALETTE_DEPTH);
    localparam int CZW = CW + ZCW;
    localparam int RZW = RW + ZCW;
    localparam int CMPW = CFG_W + 2;

    // ------------------------------------------------------------------
    // Configuration registers and clamped sizes
    // ------------------------------------------------------------------
    logic [CFG_W-1:0]  width_reg;
    logic [CFG_W-1:0]  height_reg;
    logic [ZOOM_W-1:0] zoom_reg;
    logic [WW-1:0]     w_eff;
    logic [HW-1:0]     h_eff;
    logic [ZCW-1:0]    z_eff;
    logic [DW-1:0]     zm1;
    logic [ADDR_W-1:0] stride_reg;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            width_reg  <= CFG_W'(256);
            height_reg <= CFG_W'(248);
            zoom_reg   <= ZOOM_W'(1);
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index_t'(cfg_index))
                CFG_IMAGE_WIDTH:  width_reg  <= cfg_data;
                CFG_IMAGE_HEIGHT: height_reg <= cfg_data;
                CFG_ZOOM_FACTOR:  zoom_reg   <= cfg_data[ZOOM_W-1:0];
                default:          ;  // unmapped index, ignored
            endcase
        end
    end

    // zero acts as 1, oversize saturates to the maximum
    always_comb
    begin
        if (width_reg == '0)
            w_eff = WW'(1);
        else if (CMPW'(width_reg) > CMPW'(MAX_WIDTH))
            w_eff = WW'(MAX_WIDTH);
        else
            w_eff = WW'(width_reg);

        if (height_reg == '0)
            h_eff = HW'(1);
        else if (CMPW'(height_reg) > CMPW'(MAX_HEIGHT))
            h_eff = HW'(MAX_HEIGHT);
        else
            h_eff = HW'(height_reg);

        if (zoom_reg == '0)
            z_eff = ZCW'(1);
        else if (CMPW'(zoom_reg) > CMPW'(MAX_ZOOM))
            z_eff = ZCW'(MAX_ZOOM);
        else
            z_eff = ZCW'(zoom_reg);
    end

    assign zm1 = DW'(z_eff - ZCW'(1));

    // output row pitch, registered; config must move only while idle (unenforced)
    always_ff @(posedge clk)
    begin
        stride_reg <= ADDR_W'(w_eff) * ADDR_W'(z_eff);
    end

    // ------------------------------------------------------------------
    // Input decode; code folded into the palette range by a constant table
    // ------------------------------------------------------------------
    logic [CODE_W-1:0]  in_code;
    logic [RGB_W-1:0]   in_rgb;
    logic [PW-1:0]      in_idx;
    logic [PW-1:0]      mod_lut [CODE_SPAN];
    logic               in_fire;
    logic               load_fire;
    logic               pix_fire;

    for (genvar gi = 0; gi < CODE_SPAN; gi++)
    begin : g_mod
        assign mod_lut[gi] = PW'(gi % PALETTE_DEPTH);
    end

    assign in_code   = s_axis_tdata[CODE_W-1:0];
    // stored as {red, green, blue}
    assign in_rgb    = {s_axis_tdata[CODE_W +: COLOR_W],
                        s_axis_tdata[CODE_W + COLOR_W +: COLOR_W],
                        s_axis_tdata[CODE_W + 2*COLOR_W +: COLOR_W]};
    assign in_idx    = mod_lut[in_code];
    assign in_fire   = s_axis_tvalid && s_axis_tready;
    assign load_fire = in_fire && (func_t'(s_axis_tuser) == FUNC_LOAD);
    assign pix_fire  = in_fire && (func_t'(s_axis_tuser) == FUNC_PIXEL);

    // ------------------------------------------------------------------
    // Palette RAM: one write port (loads), one registered read (pixels).
    // A pixel right after a load of the same entry reads on the next edge,
    // so it already sees the new color.
    // ------------------------------------------------------------------
    logic [RGB_W-1:0] palette_mem [PALETTE_DEPTH];
    logic [RGB_W-1:0] s1_color_reg;

    always_ff @(posedge clk)
    begin
        if (load_fire)
            palette_mem[in_idx] <= in_rgb;
        if (pix_fire)
            s1_color_reg <= palette_mem[in_idx];
    end

    // ------------------------------------------------------------------
    // Raster position counters, advanced at pixel transfer
    // ------------------------------------------------------------------
    logic [CW-1:0] column_reg, column_next;
    logic [RW-1:0] row_reg, row_next;
    logic [WW-1:0] col_cur, col_inc;
    logic [HW-1:0] row_cur, row_inc;
    logic          col_wrap;
    logic          row_wrap;
    logic          pix_last;

    always_comb
    begin
        // counters left beyond a shrunken size restart at zero
        col_cur  = (WW'(column_reg) >= w_eff) ? '0 : WW'(column_reg);
        row_cur  = (HW'(row_reg) >= h_eff) ? '0 : HW'(row_reg);
        col_inc  = col_cur + WW'(1);
        row_inc  = row_cur + HW'(1);
        col_wrap = (col_inc == w_eff);
        row_wrap = (row_inc == h_eff);
        pix_last = col_wrap && row_wrap;

        column_next = col_wrap ? '0 : CW'(col_inc);
        if (!col_wrap)
            row_next = RW'(row_cur);
        else if (row_wrap)
            row_next = '0;
        else
            row_next = RW'(row_inc);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            column_reg <= '0;
            row_reg    <= '0;
        end
        else if (pix_fire)
        begin
            column_reg <= column_next;
            row_reg    <= row_next;
        end
    end

    // ------------------------------------------------------------------
    // Pipeline: S1 (palette data) -> S2 (zoomed coordinates) -> G (writer)
    // ------------------------------------------------------------------
    logic              s1_valid_reg;
    logic [CW-1:0]     s1_col_reg;
    logic [RW-1:0]     s1_row_reg;
    logic              s1_last_reg;

    logic              s2_valid_reg;
    logic [CZW-1:0]    s2_cz_reg;
    logic [RZW-1:0]    s2_rz_reg;
    logic              s2_last_reg;
    logic [RGB_W-1:0]  s2_color_reg;

    logic              g_valid_reg;
    logic [ADDR_W-1:0] g_addr_reg;
    logic [ADDR_W-1:0] g_line_reg;
    logic [DW-1:0]     g_dx_reg;
    logic [DW-1:0]     g_dy_reg;
    logic [RGB_W-1:0]  g_color_reg;
    logic              g_last_reg;

    logic              m_fire;
    logic              g_run_end;
    logic              g_load;
    logic              s2_free;
    logic              s1_move;
    logic [ADDR_W-1:0] base_addr;
    logic [ADDR_W-1:0] next_line;

    assign m_fire    = g_valid_reg && m_axis_tready;
    assign g_run_end = (g_dx_reg == zm1) && (g_dy_reg == zm1);
    // next pixel enters the writer in the cycle its predecessor's last write goes
    assign g_load    = s2_valid_reg && (!g_valid_reg || (m_fire && g_run_end));
    assign s2_free   = !s2_valid_reg || g_load;
    assign s1_move   = s1_valid_reg && s2_free;
    assign s_axis_tready = !s1_valid_reg || s1_move;

    // top-left write of the block: (row*z)*pitch + column*z, mod 2^22
    assign base_addr = ADDR_W'(s2_rz_reg) * stride_reg + ADDR_W'(s2_cz_reg);
    assign next_line = g_line_reg + stride_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
            g_valid_reg  <= 1'b0;
        end
        else
        begin
            if (pix_fire)
                s1_valid_reg <= 1'b1;
            else if (s1_move)
                s1_valid_reg <= 1'b0;

            if (s1_move)
                s2_valid_reg <= 1'b1;
            else if (g_load)
                s2_valid_reg <= 1'b0;

            if (g_load)
                g_valid_reg <= 1'b1;
            else if (m_fire && g_run_end)
                g_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (pix_fire)
        begin
            s1_col_reg  <= CW'(col_cur);
            s1_row_reg  <= RW'(row_cur);
            s1_last_reg <= pix_last;
        end

        if (s1_move)
        begin
            s2_cz_reg    <= CZW'(s1_col_reg) * CZW'(z_eff);
            s2_rz_reg    <= RZW'(s1_row_reg) * RZW'(z_eff);
            s2_last_reg  <= s1_last_reg;
            s2_color_reg <= s1_color_reg;
        end

        // columns inner, block rows outer
        if (g_load)
        begin
            g_addr_reg  <= base_addr;
            g_line_reg  <= base_addr;
            g_dx_reg    <= '0;
            g_dy_reg    <= '0;
            g_color_reg <= s2_color_reg;
            g_last_reg  <= s2_last_reg;
        end
        else if (m_fire)
        begin
            if (g_dx_reg == zm1)
            begin
                g_dx_reg   <= '0;
                g_dy_reg   <= g_dy_reg + DW'(1);
                g_line_reg <= next_line;
                g_addr_reg <= next_line;
            end
            else
            begin
                g_dx_reg   <= g_dx_reg + DW'(1);
                g_addr_reg <= g_addr_reg + ADDR_W'(1);
            end
        end
    end

    // ------------------------------------------------------------------
    // Master side
    // ------------------------------------------------------------------
    assign m_axis_tvalid = g_valid_reg;
    assign m_axis_tdata  = {(OUT_TDATA_W - OUT_FIELD_W)'(0),
                            g_color_reg[0 +: COLOR_W],             // blue
                            g_color_reg[COLOR_W +: COLOR_W],       // green
                            g_color_reg[2*COLOR_W +: COLOR_W],     // red
                            g_addr_reg};
    assign m_axis_tlast  = g_run_end;
    assign m_axis_tuser  = g_run_end && g_last_reg;

endmodule

// File: rtl/pupw_checker.sv
// ----------------------------------------------------------------------------
// pupw_checker
// Port-level checks on the pixel write stream.
// ----------------------------------------------------------------------------
module pupw_checker
    import pupw_pkg::*;
(
    input logic                   clk,
    input logic                   rst_n,
    input logic                   m_axis_tvalid,
    input logic                   m_axis_tready,
    input logic [OUT_TDATA_W-1:0] m_axis_tdata,
    input logic                   m_axis_tlast,
    input logic                   m_axis_tuser
);

    logic [RGB_W-1:0] out_rgb;

    assign out_rgb = m_axis_tdata[ADDR_W +: RGB_W];

    // stalled write is held
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid)
        else $error("write dropped while stalled");

    a_stable: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=>
            $stable(m_axis_tdata) && $stable(m_axis_tlast) && $stable(m_axis_tuser))
        else $error("write changed while stalled");

    // frame end only on a run end
    a_frame_in_run: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && m_axis_tuser |-> m_axis_tlast)
        else $error("frame_last without run_last");

    // a run continues without a gap and keeps one color
    a_run_color: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && m_axis_tready && !m_axis_tlast |=>
            m_axis_tvalid && (out_rgb == $past(out_rgb)))
        else $error("run broken or color changed inside a run");

endmodule

bind palette_upscale_pixel_writer pupw_checker u_pupw_checker
(
    .clk           (clk),
    .rst_n         (rst_n),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast),
    .m_axis_tuser  (m_axis_tuser)
);

// File: tb/palette_upscale_pixel_writer_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// palette_upscale_pixel_writer_tb
// Self-checking bench for the palette lookup and nearest-neighbor upscaler.
// Palette loads and source pixels go in on the slave stream; every pixel write
// coming out is checked against a local model of palette, counters and
// registers. Directed cases cover reset sizes, zoom and size extremes,
// frame wrap and counters left past a shrunken size; random phases follow
// with both stream sides stalling at random, but for one phase with no stalls.
// ----------------------------------------------------------------------------
module palette_upscale_pixel_writer_tb;
    import pupw_pkg::*;

    localparam int unsigned MAX_WIDTH     = 256;
    localparam int unsigned MAX_HEIGHT    = 256;
    localparam int unsigned MAX_ZOOM      = 8;
    localparam int unsigned PALETTE_DEPTH = 256;
    localparam int unsigned ITEM_TARGET   = 450;
    localparam int unsigned IDLE_PERCENT  = 27;
    // cycles to let the pipe drain once no write is outstanding
    localparam int unsigned DRAIN_CYCLES  = 6;

    logic                   clk;
    logic                   rst_n;
    logic                   s_axis_tvalid;
    logic                   s_axis_tready;
    logic [IN_TDATA_W-1:0]  s_axis_tdata;   // code, red_in, green_in, blue_in
    logic                   s_axis_tuser;   // func
    logic                   m_axis_tvalid;
    logic                   m_axis_tready;
    logic [OUT_TDATA_W-1:0] m_axis_tdata;   // pixel_address, red, green, blue, pad
    logic                   m_axis_tlast;   // run_last
    logic                   m_axis_tuser;   // frame_last
    logic                   cfg_valid;
    logic                   cfg_ready;
    logic [CFG_IDX_W-1:0]   cfg_index;
    logic [CFG_W-1:0]       cfg_data;

    // one pixel write as it travels on the master side
    typedef struct packed
    {
        logic [ADDR_W-1:0]  addr;
        logic [COLOR_W-1:0] red;
        logic [COLOR_W-1:0] green;
        logic [COLOR_W-1:0] blue;
        logic               run_last;
        logic               frame_last;
    } pixel_write_t;

    // model state: palette, raster counters, raw register values
    logic [RGB_W-1:0]   palette_copy [PALETTE_DEPTH];
    bit                 entry_loaded [PALETTE_DEPTH];
    logic [CODE_W-1:0]  loaded_codes [$];
    int unsigned        column_pos;
    int unsigned        row_pos;
    logic [CFG_W-1:0]   width_reg;
    logic [CFG_W-1:0]   height_reg;
    logic [ZOOM_W-1:0]  zoom_reg;

    pixel_write_t       writes_due [$];

    int unsigned        mismatches;
    int unsigned        items_sent;
    int unsigned        loads_sent;
    int unsigned        pixels_sent;
    int unsigned        writes_checked;
    int unsigned        frames_seen;
    bit                 steady;     // no idling on either side while set

    palette_upscale_pixel_writer dut
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast),
        .m_axis_tuser  (m_axis_tuser),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data)
    );

    always
    begin
        clk = 1'b1;
        #2;
        clk = 1'b0;
        #2;
    end

    // hang guard, well beyond the slowest legal run
    initial
    begin
        #2_000_000;
        $display("FAIL");
        $finish;
    end

    // ------------------------------------------------------------------------
    // Model
    // ------------------------------------------------------------------------

    // zero reads as 1, anything above the maximum saturates
    function automatic int unsigned clamp_size(int unsigned raw, int unsigned top);
        if (raw == 0)
            return 1;
        if (raw > top)
            return top;
        return raw;
    endfunction

    function automatic void store_palette_entry(logic [CODE_W-1:0] code,
                                                logic [RGB_W-1:0] rgb);
        palette_copy[code] = rgb;
        if (!entry_loaded[code])
        begin
            entry_loaded[code] = 1'b1;
            loaded_codes.push_back(code);
        end
    endfunction

    // queue the zoom x zoom block of writes for one source pixel, rows outer
    function automatic void paint_block(logic [CODE_W-1:0] code);
        int unsigned  w;
        int unsigned  h;
        int unsigned  z;
        int unsigned  stride;
        int unsigned  base;
        logic [31:0]  addr;
        bit           frame_end;
        pixel_write_t wr;

        w = clamp_size(width_reg, MAX_WIDTH);
        h = clamp_size(height_reg, MAX_HEIGHT);
        z = clamp_size(zoom_reg, MAX_ZOOM);
        // counters left past a shrunken size restart at zero
        if (column_pos >= w)
            column_pos = 0;
        if (row_pos >= h)
            row_pos = 0;

        stride    = w * z;
        base      = row_pos * z * stride + column_pos * z;
        frame_end = (column_pos == w - 1) && (row_pos == h - 1);

        for (int unsigned dy = 0; dy < z; dy++)
        begin
            for (int unsigned dx = 0; dx < z; dx++)
            begin
                addr          = base + dy * stride + dx;
                wr.addr       = addr[ADDR_W-1:0];
                wr.red        = palette_copy[code][23:16];
                wr.green      = palette_copy[code][15:8];
                wr.blue       = palette_copy[code][7:0];
                wr.run_last   = (dy == z - 1) && (dx == z - 1);
                wr.frame_last = wr.run_last && frame_end;
                writes_due.push_back(wr);
            end
        end

        column_pos++;
        if (column_pos >= w)
        begin
            column_pos = 0;
            row_pos++;
            if (row_pos >= h)
                row_pos = 0;
        end
    endfunction

    // ------------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------------

    // one slave transfer; valid stays high on return so back-to-back items
    // need no extra edge
    task automatic send_item(func_t kind, logic [CODE_W-1:0] code, logic [RGB_W-1:0] rgb);
        // idle cycle by cycle, each with the same odds
        if (!steady)
        begin
            while ($urandom_range(0, 99) < IDLE_PERCENT)
            begin
                s_axis_tvalid <= 1'b0;
                @(posedge clk);
            end
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= kind;
        s_axis_tdata  <= {rgb[7:0], rgb[15:8], rgb[23:16], code};
        do
            @(posedge clk);
        while (!s_axis_tready);

        items_sent++;
        if (kind == FUNC_LOAD)
        begin
            loads_sent++;
            store_palette_entry(code, rgb);
        end
        else
        begin
            pixels_sent++;
            paint_block(code);
        end
    endtask

    // drop valid, wait for all writes, then let trailing loads settle
    task automatic wait_idle();
        s_axis_tvalid <= 1'b0;
        while (writes_due.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    // drains first, then writes all three registers back to back on the cfg channel
    task automatic configure(logic [CFG_W-1:0] width, logic [CFG_W-1:0] height,
                             logic [CFG_W-1:0] zoom);
        cfg_index_t       order  [3] = '{CFG_IMAGE_WIDTH, CFG_IMAGE_HEIGHT, CFG_ZOOM_FACTOR};
        logic [CFG_W-1:0] values [3];

        values = '{width, height, zoom};
        wait_idle();
        for (int k = 0; k < 3; k++)
        begin
            cfg_valid <= 1'b1;
            cfg_index <= order[k];
            cfg_data  <= values[k];
            do
                @(posedge clk);
            while (!cfg_ready);
            case (order[k])
                CFG_IMAGE_WIDTH:  width_reg  = values[k];
                CFG_IMAGE_HEIGHT: height_reg = values[k];
                CFG_ZOOM_FACTOR:  zoom_reg   = values[k][ZOOM_W-1:0];
                default:          ;
            endcase
        end
        cfg_valid <= 1'b0;
    endtask

    task automatic report_mismatch(string field, logic [31:0] got, logic [31:0] want);
        $display("%0t ns: write %0d %s got 0x%0h, expected 0x%0h",
                 $realtime, writes_checked, field, got, want);
        mismatches++;
    endtask

    // ------------------------------------------------------------------------
    // Receiver: random stalls plus the write checker
    // ------------------------------------------------------------------------
    always @(posedge clk)
    begin
        pixel_write_t got;
        pixel_write_t want;

        if (!rst_n)
            m_axis_tready <= 1'b0;
        else
        begin
            m_axis_tready <= steady || ($urandom_range(0, 99) >= IDLE_PERCENT);
            if (m_axis_tvalid && m_axis_tready)
            begin
                got.addr       = m_axis_tdata[ADDR_W-1:0];
                got.red        = m_axis_tdata[ADDR_W +: COLOR_W];
                got.green      = m_axis_tdata[ADDR_W + COLOR_W +: COLOR_W];
                got.blue       = m_axis_tdata[ADDR_W + 2*COLOR_W +: COLOR_W];
                got.run_last   = m_axis_tlast;
                got.frame_last = m_axis_tuser;
                if (writes_due.size() == 0)
                    report_mismatch("unexpected write, address", 32'(got.addr), '0);
                else
                begin
                    want = writes_due.pop_front();
                    if (got.addr !== want.addr)
                        report_mismatch("pixel_address", 32'(got.addr), 32'(want.addr));
                    if (got.red !== want.red)
                        report_mismatch("red", 32'(got.red), 32'(want.red));
                    if (got.green !== want.green)
                        report_mismatch("green", 32'(got.green), 32'(want.green));
                    if (got.blue !== want.blue)
                        report_mismatch("blue", 32'(got.blue), 32'(want.blue));
                    if (got.run_last !== want.run_last)
                        report_mismatch("run_last", 32'(got.run_last), 32'(want.run_last));
                    if (got.frame_last !== want.frame_last)
                        report_mismatch("frame_last", 32'(got.frame_last),
                                        32'(want.frame_last));
                end
                if (got.frame_last === 1'b1)
                    frames_seen++;
                writes_checked++;
            end
        end
    end

    // ------------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------------

    // reset sizes (256 x 248, zoom 1); darkest, brightest and mixed entries
    task automatic test_reset_defaults();
        send_item(FUNC_LOAD, 8'h00, 24'h000000);
        send_item(FUNC_LOAD, 8'hFF, 24'hFFFFFF);
        send_item(FUNC_LOAD, 8'h5A, 24'hA55AC3);
        send_item(FUNC_LOAD, 8'hA5, 24'h5AA53C);
        send_item(FUNC_PIXEL, 8'h00, 24'h000000);
        send_item(FUNC_PIXEL, 8'hFF, 24'hFFFFFF);
    endtask

    // largest zoom, zero zoom (reads as 1), zoom above the maximum
    task automatic test_zoom_extremes();
        configure(9'd256, 9'd248, 9'd8);
        send_item(FUNC_PIXEL, 8'hFF, 24'h000000);
        configure(9'd256, 9'd248, 9'd0);
        send_item(FUNC_PIXEL, 8'h00, 24'h000000);
        configure(9'd256, 9'd248, 9'd15);
        send_item(FUNC_PIXEL, 8'h5A, 24'h000000);
    endtask

    // zero sizes give a one-pixel frame; oversize values saturate
    task automatic test_size_saturation();
        configure(9'd0, 9'd0, 9'd2);
        send_item(FUNC_PIXEL, 8'hA5, 24'h000000);
        send_item(FUNC_PIXEL, 8'h5A, 24'h000000);
        configure(9'd511, 9'd300, 9'd1);
        send_item(FUNC_PIXEL, 8'hFF, 24'h000000);
        send_item(FUNC_PIXEL, 8'h00, 24'h000000);
    endtask

    // 2 x 2 frame at zoom 2: frame end on the fourth pixel, then row wrap
    task automatic test_frame_wrap();
        configure(9'd2, 9'd2, 9'd2);
        repeat (5) send_item(FUNC_PIXEL, 8'hA5, 24'h000000);
    endtask

    // leave column and row beyond a smaller size, both must restart at zero
    task automatic test_counter_shrink();
        configure(9'd4, 9'd3, 9'd1);
        repeat (6) send_item(FUNC_PIXEL, 8'h5A, 24'h000000);
        configure(9'd2, 9'd1, 9'd3);
        send_item(FUNC_PIXEL, 8'hFF, 24'h000000);
        send_item(FUNC_PIXEL, 8'h00, 24'h000000);
    endtask

    function automatic logic [CFG_W-1:0] pick_size();
        case ($urandom_range(0, 9))
            0:       return 9'd0;
            1:       return 9'd256;
            2:       return CFG_W'($urandom_range(257, 511));
            3:       return 9'd1;
            default: return CFG_W'($urandom_range(2, 6));
        endcase
    endfunction

    // random phases: new sizes, then a burst of pixels mixed with loads
    task automatic test_random_traffic();
        int unsigned       phase;
        logic [ZOOM_W-1:0] zoom;
        logic [CODE_W-1:0] code;

        phase = 0;
        while (items_sent < ITEM_TARGET)
        begin
            case ($urandom_range(0, 9))
                0:       zoom = 4'd0;
                1:       zoom = 4'd8;
                2:       zoom = ZOOM_W'($urandom_range(9, 15));
                3:       zoom = 4'd1;
                default: zoom = ZOOM_W'($urandom_range(2, 3));
            endcase
            // upper data bits are ignored for the zoom register
            configure(pick_size(), pick_size(), {5'($urandom), zoom});
            // one whole phase with no stalls anywhere
            steady = (phase == 4);
            repeat ($urandom_range(8, 40))
            begin
                if ($urandom_range(0, 3) == 0)
                    send_item(FUNC_LOAD, CODE_W'($urandom_range(0, 255)), RGB_W'($urandom));
                else
                begin
                    // only entries already loaded are ever looked up
                    code = loaded_codes[$urandom_range(0, loaded_codes.size() - 1)];
                    send_item(FUNC_PIXEL, code, RGB_W'($urandom));
                end
            end
            phase++;
        end
        steady = 1'b0;
    endtask

    // ------------------------------------------------------------------------
    // Sequence
    // ------------------------------------------------------------------------
    initial
    begin
        rst_n         = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        s_axis_tuser  = FUNC_LOAD;
        m_axis_tready = 1'b0;
        cfg_valid     = 1'b0;
        cfg_index     = CFG_IMAGE_WIDTH;
        cfg_data      = '0;
        steady        = 1'b0;
        mismatches    = 0;
        items_sent    = 0;
        loads_sent    = 0;
        pixels_sent   = 0;
        writes_checked = 0;
        frames_seen   = 0;
        column_pos    = 0;
        row_pos       = 0;
        width_reg     = 9'd256;
        height_reg    = 9'd248;
        zoom_reg      = 4'd1;

        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_reset_defaults();
        test_zoom_extremes();
        test_size_saturation();
        test_frame_wrap();
        test_counter_shrink();
        test_random_traffic();

        wait_idle();
        repeat (16) @(posedge clk);

        $display("covered %0d items (%0d palette loads, %0d pixels) over several sizes and zooms",
                 items_sent, loads_sent, pixels_sent);
        $display("%0d pixel writes checked, %0d frame ends, %0d mismatches",
                 writes_checked, frames_seen, mismatches);
        if (mismatches == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule
